FILE: sv/rumble_pattern_player_defines.svh
// assertion helpers for the rumble pattern player
`ifndef RUMBLE_PATTERN_PLAYER_DEFINES_SVH
`define RUMBLE_PATTERN_PLAYER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define RPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define RPP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rpp_pkg.sv
package rpp_pkg;

  // default sizes
  localparam int NUM_SLOTS_DEF  = 4;
  localparam int MAX_FRAMES_DEF = 64;

  // field widths
  localparam int MODE_W     = 2;
  localparam int HASH_W     = 32;
  localparam int BITS_W     = 64;
  localparam int LEN_W      = 7;
  localparam int SLOT_IDX_W = 4;
  localparam int STAMP_W    = 31;
  localparam int LIMIT_W    = 12;
  localparam int REL_W      = 4;
  localparam int HOLD_W     = 5;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // reset values
  localparam logic [LIMIT_W-1:0] OVERHEAT_RST = LIMIT_W'(1800);
  localparam logic [REL_W-1:0]   RELEASE_RST  = REL_W'(5);
  localparam logic [STAMP_W-1:0] STAMP_RST    = STAMP_W'(1);
  localparam int                 HOLD_FLOOR   = -9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_STOP = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic clear;
  } slot_ctrl_t;

  typedef struct packed {
    logic               busy;
    logic [HASH_W-1:0]  hash;
    logic [STAMP_W-1:0] stamp;
    logic               tick_level;
  } slot_stat_t;

  typedef struct packed {
    logic tick;
    logic stop;
  } motor_ctrl_t;

endpackage

FILE: sv/rpp_if.sv
interface rpp_in_if;
  logic                          valid;
  logic                          ready;
  logic [rpp_pkg::MODE_W-1:0]    mode;
  logic [rpp_pkg::HASH_W-1:0]    pattern_hash;
  logic [rpp_pkg::BITS_W-1:0]    pattern_bits;
  logic [rpp_pkg::LEN_W-1:0]     pattern_length;
  logic                          loop_flag;

  modport source (output valid, mode, pattern_hash, pattern_bits, pattern_length, loop_flag,
                  input ready);
  modport sink (input valid, mode, pattern_hash, pattern_bits, pattern_length, loop_flag,
                output ready);
endinterface

interface rpp_out_if;
  logic                          valid;
  logic                          ready;
  logic [rpp_pkg::CMD_W-1:0]     motor_command;
  logic                          motor_on;
  logic                          accepted;
  logic [rpp_pkg::SLOT_IDX_W-1:0] slot_index;
  logic                          cooling;

  modport source (output valid, motor_command, motor_on, accepted, slot_index, cooling,
                  input ready);
  modport sink (input valid, motor_command, motor_on, accepted, slot_index, cooling,
                output ready);
endinterface

interface rpp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rpp_pkg::CFG_IDX_W-1:0]    index;
  logic [rpp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/rpp_slot.sv
module rpp_slot #(
  parameter int MAX_FRAMES = rpp_pkg::MAX_FRAMES_DEF,
  localparam int POS_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpp_pkg::slot_ctrl_t           ctrl,
  input  logic [rpp_pkg::HASH_W-1:0]    ld_hash,
  input  logic [MAX_FRAMES-1:0]         ld_bits,
  input  logic [POS_W-1:0]              ld_len,
  input  logic                          ld_repeat,
  input  logic [rpp_pkg::STAMP_W-1:0]   ld_stamp,
  output rpp_pkg::slot_stat_t           stat
);

  logic                        busy_r, busy_nxt;
  logic                        level_r, level_nxt;
  logic [rpp_pkg::HASH_W-1:0]  hash_r;
  logic [MAX_FRAMES-1:0]       bits_r;
  logic [POS_W-1:0]            len_r;
  logic                        rep_r;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [rpp_pkg::STAMP_W-1:0] stamp_r;
  logic [MAX_FRAMES-1:0]       shifted;

  // frame advance as one tick would do it
  always_comb begin
    shifted   = bits_r >> pos_r;
    busy_nxt  = busy_r;
    level_nxt = level_r;
    pos_nxt   = pos_r;
    if (busy_r) begin
      if (pos_r >= len_r) begin
        if (rep_r) begin
          level_nxt = bits_r[0];
          pos_nxt   = POS_W'(1);
        end else begin
          busy_nxt  = 1'b0;
          level_nxt = 1'b0;
        end
      end else begin
        level_nxt = shifted[0];
        pos_nxt   = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= 1'b0;
    end else if (ctrl.clear) begin
      busy_r  <= 1'b0;
      level_r <= 1'b0;
    end else if (ctrl.load) begin
      busy_r <= 1'b1;
    end else if (ctrl.tick) begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hash_r  <= ld_hash;
      bits_r  <= ld_bits;
      len_r   <= ld_len;
      rep_r   <= ld_repeat;
      pos_r   <= '0;
      stamp_r <= ld_stamp;
    end else if (ctrl.tick) begin
      pos_r <= pos_nxt;
    end
  end

  assign stat.busy       = busy_r;
  assign stat.hash       = hash_r;
  assign stat.stamp      = stamp_r;
  assign stat.tick_level = level_nxt;

endmodule

FILE: sv/rpp_alloc.sv
module rpp_alloc #(
  parameter int NUM_SLOTS = rpp_pkg::NUM_SLOTS_DEF
) (
  input  rpp_pkg::slot_stat_t               stat [NUM_SLOTS],
  input  logic [rpp_pkg::HASH_W-1:0]        hash,
  output logic                              dup,
  output logic [NUM_SLOTS-1:0]              pick_oh,
  output logic [rpp_pkg::SLOT_IDX_W-1:0]    pick_idx
);

  logic [NUM_SLOTS-1:0] dup_vec;
  logic [NUM_SLOTS-1:0] empty_vec;
  logic [NUM_SLOTS-1:0] oldest_vec;
  logic [NUM_SLOTS-1:0] cand;
  logic                 seen;

  // all pairwise stamp compares in parallel; ties go to the lower index
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      dup_vec[i]    = stat[i].busy && (stat[i].hash == hash);
      empty_vec[i]  = !stat[i].busy;
      oldest_vec[i] = 1'b1;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j < i && !(stat[i].stamp < stat[j].stamp)) oldest_vec[i] = 1'b0;
        if (j > i && (stat[i].stamp > stat[j].stamp)) oldest_vec[i] = 1'b0;
      end
    end
  end

  assign dup  = |dup_vec;
  assign cand = dup ? dup_vec : ((|empty_vec) ? empty_vec : oldest_vec);

  // first candidate wins
  always_comb begin
    pick_oh  = '0;
    pick_idx = '0;
    seen     = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cand[i] && !seen) begin
        pick_oh[i] = 1'b1;
        pick_idx   = rpp_pkg::SLOT_IDX_W'(i);
        seen       = 1'b1;
      end
    end
  end

endmodule

FILE: sv/rpp_motor.sv
module rpp_motor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rpp_pkg::motor_ctrl_t           ctrl,
  input  logic                           req,
  input  logic [rpp_pkg::LIMIT_W-1:0]    limit,
  input  logic [rpp_pkg::REL_W-1:0]      rel,
  output rpp_pkg::cmd_t                  cmd,
  output logic                           motor_on_nxt,
  output logic                           cool_nxt
);

  localparam int HW = rpp_pkg::HOLD_W;
  localparam int LW = rpp_pkg::LIMIT_W;
  localparam logic signed [HW:0] HOLD_FLOOR_S = (HW+1)'(rpp_pkg::HOLD_FLOOR);

  logic                  motor_r, tick_motor;
  logic                  cool_r, tick_cool;
  logic signed [HW-1:0]  hold_r, hold_nxt;
  logic [LW-1:0]         run_r, run_nxt;
  logic signed [HW:0]    hdec, hrel;
  logic [LW:0]           run_inc;
  rpp_pkg::cmd_t         tick_cmd;

  always_comb begin
    tick_motor = motor_r;
    tick_cool  = cool_r;
    hold_nxt   = hold_r;
    run_nxt    = run_r;
    tick_cmd   = rpp_pkg::CMD_NONE;
    hdec       = $signed({hold_r[HW-1], hold_r}) - (HW+1)'(1);
    hrel       = $signed({2'b00, rel});
    run_inc    = {1'b0, run_r} + (LW+1)'(1);
    if (cool_r) begin
      // cooldown: count down, stop on every tick
      tick_cmd = rpp_pkg::CMD_STOP;
      if (run_r <= LW'(1)) begin
        tick_cool = 1'b0;
        run_nxt   = '0;
      end else begin
        run_nxt = run_r - LW'(1);
      end
    end else begin
      if (req) begin
        if (!motor_r) begin
          tick_motor = 1'b1;
          tick_cmd   = rpp_pkg::CMD_START;
        end
        hold_nxt = $signed({1'b0, rel});
      end else begin
        if (motor_r) begin
          tick_motor = 1'b0;
          tick_cmd   = rpp_pkg::CMD_STOP;
        end
        if (hdec < HOLD_FLOOR_S) hdec = HOLD_FLOOR_S;
        if (hdec > hrel) hdec = hrel;
        hold_nxt = hdec[HW-1:0];
      end
      if (!req && hdec[HW]) begin
        run_nxt = '0;
      end else if (run_inc > {1'b0, limit}) begin
        tick_cool = 1'b1;
        run_nxt   = limit;
      end else begin
        run_nxt = run_inc[LW-1:0];
      end
    end
  end

  always_comb begin
    cmd          = rpp_pkg::CMD_NONE;
    motor_on_nxt = motor_r;
    cool_nxt     = cool_r;
    if (ctrl.tick) begin
      cmd          = tick_cmd;
      motor_on_nxt = tick_motor;
      cool_nxt     = tick_cool;
    end else if (ctrl.stop) begin
      cmd          = rpp_pkg::CMD_STOP;
      motor_on_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_r <= 1'b0;
      cool_r  <= 1'b0;
      hold_r  <= '0;
      run_r   <= '0;
    end else if (ctrl.tick) begin
      motor_r <= tick_motor;
      cool_r  <= tick_cool;
      hold_r  <= hold_nxt;
      run_r   <= run_nxt;
    end else if (ctrl.stop) begin
      motor_r <= 1'b0;
    end
  end

endmodule

FILE: sv/rumble_pattern_player.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    mode, pattern_hash, pattern_bits, pattern_length, loop_flag
// out_ch    out  valid/ready    motor_command, motor_on, accepted, slot_index, cooling
// cfg_ch    in   valid/ready    index, data (0 overheat_limit, 1 release_hold)
//
// every item goes through the input register, one pass of slot/allocation/motor logic and the
// result register; an item can be accepted every cycle while out_ch.ready does not stall it
// an accepted item reaches out_ch.valid through the input register and then the result register
// rst_n is synchronous, active low; no clearing pass, slots are free right after reset
// out_ch.ready low holds the result register and then the input register, so in_ch.ready
// falls only once both are full
// cfg_ch is always ready

`include "rumble_pattern_player_defines.svh"

module rumble_pattern_player #(
  parameter int NUM_SLOTS  = rpp_pkg::NUM_SLOTS_DEF,
  parameter int MAX_FRAMES = rpp_pkg::MAX_FRAMES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rpp_in_if.sink   in_ch,
  rpp_out_if.source out_ch,
  rpp_cfg_if.sink  cfg_ch
);

  localparam int POS_W = $clog2(MAX_FRAMES + 1);

  // configuration registers
  logic [rpp_pkg::LIMIT_W-1:0] limit_r;
  logic [rpp_pkg::REL_W-1:0]   rel_r;

  // input register
  logic                         in_vld_r;
  logic [rpp_pkg::MODE_W-1:0]   in_mode_r;
  logic [rpp_pkg::HASH_W-1:0]   in_hash_r;
  logic [rpp_pkg::BITS_W-1:0]   in_bits_r;
  logic [rpp_pkg::LEN_W-1:0]    in_len_r;
  logic                         in_loop_r;

  // result register
  logic                           out_vld_r;
  rpp_pkg::cmd_t                  out_cmd_r, out_cmd_nxt;
  logic                           out_on_r, out_on_nxt;
  logic                           out_acc_r, out_acc_nxt;
  logic [rpp_pkg::SLOT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                           out_cool_r, out_cool_nxt;

  // load sequence stamp
  logic [rpp_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;

  logic                 fire;
  logic                 is_tick, is_load, is_stop;
  rpp_pkg::mode_t       mode;
  logic [POS_W-1:0]     ld_len;
  logic                 dup;
  logic                 do_load;
  logic [NUM_SLOTS-1:0] pick_oh;
  logic [NUM_SLOTS-1:0] load_vec;
  logic [NUM_SLOTS-1:0] busy_vec;
  logic [NUM_SLOTS-1:0] level_vec;
  logic [rpp_pkg::SLOT_IDX_W-1:0] pick_idx;
  rpp_pkg::slot_stat_t  stat [NUM_SLOTS];
  rpp_pkg::motor_ctrl_t mctrl;
  rpp_pkg::cmd_t        motor_cmd;
  logic                 motor_on_nxt;
  logic                 cool_nxt;

  // an item in the input register moves on when the result register frees up
  assign fire        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || fire;
  assign cfg_ch.ready = 1'b1;

  assign mode = rpp_pkg::mode_t'(in_mode_r);

  always_comb begin
    is_tick = 1'b0;
    is_load = 1'b0;
    is_stop = 1'b0;
    case (mode)
      rpp_pkg::MODE_TICK: is_tick = 1'b1;
      rpp_pkg::MODE_LOAD: is_load = 1'b1;
      rpp_pkg::MODE_STOP: is_stop = 1'b1;
      default: ;  // unused mode leaves everything alone
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rpp_pkg::OVERHEAT_RST;
      rel_r   <= rpp_pkg::RELEASE_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == rpp_pkg::CFG_OVERHEAT) begin
        limit_r <= cfg_ch.data[rpp_pkg::LIMIT_W-1:0];
      end else if (cfg_ch.index == rpp_pkg::CFG_RELEASE) begin
        rel_r <= cfg_ch.data[rpp_pkg::REL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode_r <= in_ch.mode;
      in_hash_r <= in_ch.pattern_hash;
      in_bits_r <= in_ch.pattern_bits;
      in_len_r  <= in_ch.pattern_length;
      in_loop_r <= in_ch.loop_flag;
    end
  end

  // lengths past the slot capacity saturate
  assign ld_len = (in_len_r > rpp_pkg::LEN_W'(MAX_FRAMES)) ? POS_W'(MAX_FRAMES)
                                                           : POS_W'(in_len_r);

  // a new load is stamped with the advanced counter, wrapping at 31 bits
  assign stamp_nxt = stamp_r + rpp_pkg::STAMP_W'(1);
  assign do_load   = fire && is_load && !dup;
  assign load_vec  = do_load ? pick_oh : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= rpp_pkg::STAMP_RST;
    end else if (do_load) begin
      stamp_r <= stamp_nxt;
    end
  end

  // pattern slots
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    rpp_pkg::slot_ctrl_t sctrl;

    assign sctrl.tick  = fire && is_tick;
    assign sctrl.load  = load_vec[g];
    assign sctrl.clear = fire && is_stop;

    rpp_slot #(
      .MAX_FRAMES (MAX_FRAMES)
    ) u_slot (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (sctrl),
      .ld_hash   (in_hash_r),
      .ld_bits   (in_bits_r[MAX_FRAMES-1:0]),
      .ld_len    (ld_len),
      .ld_repeat (in_loop_r),
      .ld_stamp  (stamp_nxt),
      .stat      (stat[g])
    );

    assign busy_vec[g]  = stat[g].busy;
    assign level_vec[g] = stat[g].tick_level;
  end

  // duplicate check, then lowest free slot, then oldest stamp
  rpp_alloc #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_alloc (
    .stat     (stat),
    .hash     (in_hash_r),
    .dup      (dup),
    .pick_oh  (pick_oh),
    .pick_idx (pick_idx)
  );

  // motor request is the OR of every slot level after the tick
  assign mctrl.tick = fire && is_tick;
  assign mctrl.stop = fire && is_stop;

  rpp_motor u_motor (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (mctrl),
    .req          (|level_vec),
    .limit        (limit_r),
    .rel          (rel_r),
    .cmd          (motor_cmd),
    .motor_on_nxt (motor_on_nxt),
    .cool_nxt     (cool_nxt)
  );

  // result fields
  always_comb begin
    out_cmd_nxt  = motor_cmd;
    out_on_nxt   = motor_on_nxt;
    out_cool_nxt = cool_nxt;
    out_acc_nxt  = is_load && !dup;
    out_idx_nxt  = is_load ? pick_idx : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_cmd_r  <= out_cmd_nxt;
      out_on_r   <= out_on_nxt;
      out_acc_r  <= out_acc_nxt;
      out_idx_r  <= out_idx_nxt;
      out_cool_r <= out_cool_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.motor_command = out_cmd_r;
  assign out_ch.motor_on      = out_on_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.slot_index    = out_idx_r;
  assign out_ch.cooling       = out_cool_r;

  // a load fills at most one slot
  `RPP_ASSERT_IMP(a_one_load, 1'b1, $onehot0(load_vec), "more than one slot loaded")
  // stop all frees every slot
  `RPP_ASSERT_NXT(a_stop_frees, fire && is_stop, busy_vec == '0, "slot busy after stop")
  // a placed load names a slot that exists
  `RPP_ASSERT_IMP(a_slot_range, out_vld_r && out_acc_r, int'(out_idx_r) < NUM_SLOTS,
    "load placed outside the slot range")

endmodule
